FILE: rtl/lste_pkg.sv
// shared types, constants and command codes of the lsb stego text extractor
`default_nettype none
package lste_pkg;

  localparam int MARK_LEN   = 28;
  localparam int HOLD_DEPTH = MARK_LEN - 1;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

  // end marker text, first character first
  localparam logic [7:0] END_MARK [MARK_LEN] = '{
    8'h2F, 8'h2A, 8'h34, 8'h30, 8'h34, 8'h20, 8'h45, 8'h4E, 8'h44, 8'h20,
    8'h4F, 8'h46, 8'h20, 8'h46, 8'h4F, 8'h52, 8'h4D, 8'h41, 8'h54, 8'h45,
    8'h44, 8'h20, 8'h43, 8'h4F, 8'h44, 8'h45, 8'h2A, 8'h2F
  };

  // result source codes
  localparam logic [1:0] OUT_HELD  = 2'd0;
  localparam logic [1:0] OUT_FOUND = 2'd1;
  localparam logic [1:0] OUT_NULL  = 2'd2;

  typedef struct packed {
    logic [7:0] channel_byte;
    logic       end_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       marker_found;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       shift_bit;
    logic       store_byte;
    logic       clear_bits;
    logic       clear_held;
    logic       pop;
    logic       load_out;
    logic [1:0] out_sel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic byte_done;
    logic marker_hit;
    logic held_full;
    logic held_empty;
    logic held_one;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/lste_datapath.sv
// bit assembler, 27-byte delay line, marker compare and result register
`default_nettype none
module lste_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lste_pkg::in_item_t in_data,
  input  wire lste_pkg::cmd_t    cmd,
  output      lste_pkg::status_t sts,
  input  wire logic              out_stall,
  output      logic              out_valid,
  output      lste_pkg::out_item_t out_data
);

  logic [2:0]                 bit_count_r, bit_count_nxt;
  logic [7:0]                 partial_r, partial_nxt;
  logic [7:0]                 held_r   [lste_pkg::HOLD_DEPTH];
  logic [7:0]                 held_nxt [lste_pkg::HOLD_DEPTH];
  logic [lste_pkg::CNT_W-1:0] held_count_r, held_count_nxt;
  logic                       match_r, match_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lste_pkg::out_item_t        out_data_r, out_data_nxt;
  logic [7:0]                 newest;
  logic                       held_full;

  assign newest    = {partial_r[6:0], in_data.channel_byte[0]};
  assign held_full = (held_count_r == lste_pkg::CNT_W'(lste_pkg::HOLD_DEPTH));

  assign sts.byte_done  = (bit_count_r == 3'd7);
  assign sts.marker_hit = match_r && (newest == lste_pkg::END_MARK[lste_pkg::MARK_LEN-1]);
  assign sts.held_full  = held_full;
  assign sts.held_empty = (held_count_r == '0);
  assign sts.held_one   = (held_count_r == lste_pkg::CNT_W'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  // bit assembly, msb first
  always_comb begin
    bit_count_nxt = bit_count_r;
    partial_nxt   = partial_r;
    if (cmd.clear_bits) begin
      bit_count_nxt = '0;
      partial_nxt   = '0;
    end else if (cmd.shift_bit) begin
      bit_count_nxt = bit_count_r + 3'd1;
      partial_nxt   = (bit_count_r == 3'd7) ? 8'd0 : newest;
    end
  end

  // delay line: oldest at entry 0
  always_comb begin
    held_nxt       = held_r;
    held_count_nxt = held_count_r;
    if (cmd.clear_held) begin
      held_count_nxt = '0;
    end else if (cmd.pop || (cmd.store_byte && held_full)) begin
      for (int i = 0; i < lste_pkg::HOLD_DEPTH - 1; i++) begin
        held_nxt[i] = held_r[i+1];
      end
      if (cmd.store_byte) begin
        held_nxt[lste_pkg::HOLD_DEPTH-1] = newest;
      end else begin
        held_count_nxt = held_count_r - lste_pkg::CNT_W'(1);
      end
    end else if (cmd.store_byte) begin
      for (int i = 0; i < lste_pkg::HOLD_DEPTH; i++) begin
        if (held_count_r == lste_pkg::CNT_W'(i)) begin
          held_nxt[i] = newest;
        end
      end
      held_count_nxt = held_count_r + lste_pkg::CNT_W'(1);
    end
  end

  // full line against the first 27 marker bytes, refreshed every cycle
  always_comb begin
    match_nxt = held_full;
    for (int i = 0; i < lste_pkg::HOLD_DEPTH; i++) begin
      if (held_r[i] != lste_pkg::END_MARK[i]) begin
        match_nxt = 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.out_sel)
        lste_pkg::OUT_HELD:  out_data_nxt = '{held_r[0], 1'b1, 1'b0, cmd.out_last};
        lste_pkg::OUT_FOUND: out_data_nxt = '{8'd0, 1'b0, 1'b1, 1'b1};
        lste_pkg::OUT_NULL:  out_data_nxt = '{8'd0, 1'b0, 1'b0, 1'b1};
        default:             out_data_nxt = '{8'd0, 1'b0, 1'b0, 1'b1};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= '0;
      partial_r    <= '0;
      held_count_r <= '0;
      match_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bit_count_r  <= bit_count_nxt;
      partial_r    <= partial_nxt;
      held_count_r <= held_count_nxt;
      match_r      <= match_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/lste_ctrl.sv
// controller: run and flush states, stopped flag, datapath commands
`default_nettype none
module lste_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire lste_pkg::in_item_t in_data,
  output      logic              in_stall,
  input  wire lste_pkg::status_t sts,
  output      lste_pkg::cmd_t    cmd
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic state_r, state_nxt;
  logic stopped_r, stopped_nxt;
  logic take;
  logic eoi;
  logic hit;

  assign take     = in_valid && sts.out_free && (state_r == ST_RUN);
  assign in_stall = !(sts.out_free && (state_r == ST_RUN));
  assign eoi      = in_data.end_of_image;
  assign hit      = sts.byte_done && sts.marker_hit;

  always_comb begin
    cmd         = '0;
    cmd.out_sel = lste_pkg::OUT_HELD;
    state_nxt   = state_r;
    stopped_nxt = stopped_r;
    unique case (state_r)
      ST_RUN: begin
        if (take && stopped_r) begin
          if (eoi) begin
            stopped_nxt    = 1'b0;
            cmd.clear_bits = 1'b1;
          end
        end else if (take) begin
          cmd.shift_bit = 1'b1;
          if (hit) begin
            cmd.load_out   = 1'b1;
            cmd.out_sel    = lste_pkg::OUT_FOUND;
            cmd.out_last   = 1'b1;
            cmd.clear_held = 1'b1;
            cmd.clear_bits = 1'b1;
            stopped_nxt    = !eoi;
          end else begin
            if (sts.byte_done) begin
              cmd.store_byte = 1'b1;
              if (sts.held_full) begin
                cmd.load_out = 1'b1;
                cmd.out_sel  = lste_pkg::OUT_HELD;
              end
            end
            if (eoi) begin
              cmd.clear_bits = 1'b1;
              if (sts.held_empty && !sts.byte_done) begin
                cmd.load_out = 1'b1;
                cmd.out_sel  = lste_pkg::OUT_NULL;
                cmd.out_last = 1'b1;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = lste_pkg::OUT_HELD;
          cmd.out_last = sts.held_one;
          cmd.pop      = 1'b1;
          if (sts.held_one) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      stopped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lsb_stego_text_extractor.sv
// top level of the lsb stego text extractor: controller plus datapath
`default_nettype none
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  channel_byte, end_of_image
// out_      output     out_valid/out_stall  text_byte, byte_valid, marker_found, last
//
// one item a cycle unless in_stall holds it; every eighth item can push a byte out
// end of image without the marker drains the 27-entry delay line, one result a cycle
//   unless the output stalls, through the single result register
// synchronous active-low reset clears control state; delay line contents are not cleared
// a stalled result holds the result register and blocks further input, nothing is lost
module lsb_stego_text_extractor (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire lste_pkg::in_item_t  in_data,
  output      logic                in_stall,
  output      logic                out_valid,
  output      lste_pkg::out_item_t out_data,
  input  wire logic                out_stall
);

  lste_pkg::cmd_t    cmd;
  lste_pkg::status_t sts;

  // sequencing: run / flush, stopped after the marker
  lste_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bits to bytes, delay line, marker compare, result register
  lste_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // result register is never overwritten while a result still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result register overwritten");

  // draining the delay line never overlaps taking input
  a_pop_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> in_stall)
    else $error("input taken during flush");

  // a found result drops the held bytes
  a_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_sel == lste_pkg::OUT_FOUND) |=> sts.held_empty)
    else $error("held bytes kept after marker");

  // a result never claims both a byte and the marker
  a_found_or_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.byte_valid && out_data.marker_found))
    else $error("result carries byte and marker");

endmodule
`default_nettype wire
